@@ design/tpwm_pkg.sv @@
// Shared types, constants and register codes of the PWM generator with dead band.
`default_nettype none
package tpwm_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int CH_BITS      = 1;
  localparam int DUTY_BITS    = 10;
  localparam int DEAD_BITS    = 7;
  localparam int DEADC_BITS   = DEAD_BITS + 2;
  localparam int TIMER_BITS   = 8;
  localparam int CFG_BITS     = 8;
  localparam int IDX_BITS     = 3;

  localparam logic [3:0] PRESCALE_LIMIT_1  = 4'd0;
  localparam logic [3:0] PRESCALE_LIMIT_4  = 4'd3;
  localparam logic [3:0] PRESCALE_LIMIT_16 = 4'd15;

  typedef enum logic [IDX_BITS-1:0] {
    REG_PERIOD      = 3'd0,
    REG_PRESCALE    = 3'd1,
    REG_TIMER_ON    = 3'd2,
    REG_OUTPUT_MODE = 3'd3,
    REG_POLARITY    = 3'd4,
    REG_DEAD_BAND   = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    PRESCALE_DIV1  = 2'd0,
    PRESCALE_DIV4  = 2'd1,
    PRESCALE_DIV16 = 2'd2
  } prescale_code_t;

  typedef enum logic {
    KIND_TICK       = 1'b0,
    KIND_DUTY_WRITE = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [TIMER_BITS-1:0] period;
    logic [1:0]            prescale_select;
    logic                  timer_on;
    logic                  output_mode;
    logic [1:0]            polarity;
    logic [DEAD_BITS-1:0]  dead_band;
  } cfg_t;

  typedef struct packed {
    logic                 kind;
    logic [CH_BITS-1:0]   channel;
    logic [DUTY_BITS-1:0] duty_value;
  } item_t;

  typedef struct packed {
    logic                  out_a;
    logic                  out_b;
    logic                  out_second;
    logic                  period_match;
    logic [TIMER_BITS-1:0] timer_value;
  } result_t;

endpackage
`default_nettype wire

@@ design/tpwm_if.sv @@
// Valid/ready channel interfaces for the command and result streams.
`default_nettype none
interface tpwm_cmd_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [tpwm_pkg::CH_BITS-1:0]   channel;
  logic [tpwm_pkg::DUTY_BITS-1:0] duty_value;

  modport source (output valid, output kind, output channel, output duty_value, input ready);
  modport sink (input valid, input kind, input channel, input duty_value, output ready);
endinterface

interface tpwm_res_if;
  logic                            valid;
  logic                            ready;
  logic                            out_a;
  logic                            out_b;
  logic                            out_second;
  logic                            period_match;
  logic [tpwm_pkg::TIMER_BITS-1:0] timer_value;

  modport source (output valid, output out_a, output out_b, output out_second,
                  output period_match, output timer_value, input ready);
  modport sink (input valid, input out_a, input out_b, input out_second,
                input period_match, input timer_value, output ready);
endinterface
`default_nettype wire

@@ design/tpwm_regs.sv @@
// Configuration register file written through the plain write port.
`default_nettype none
module tpwm_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [tpwm_pkg::IDX_BITS-1:0]     cfg_index,
  input  wire logic [tpwm_pkg::CFG_BITS-1:0]     cfg_data,
  output tpwm_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period          <= '1;
      cfg.prescale_select <= tpwm_pkg::PRESCALE_DIV1;
      cfg.timer_on        <= 1'b0;
      cfg.output_mode     <= 1'b0;
      cfg.polarity        <= 2'b00;
      cfg.dead_band       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tpwm_pkg::REG_PERIOD:      cfg.period          <= cfg_data;
        tpwm_pkg::REG_PRESCALE:    cfg.prescale_select <= cfg_data[1:0];
        tpwm_pkg::REG_TIMER_ON:    cfg.timer_on        <= cfg_data[0];
        tpwm_pkg::REG_OUTPUT_MODE: cfg.output_mode     <= cfg_data[0];
        tpwm_pkg::REG_POLARITY:    cfg.polarity        <= cfg_data[1:0];
        tpwm_pkg::REG_DEAD_BAND:   cfg.dead_band       <= cfg_data[tpwm_pkg::DEAD_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/tpwm_core.sv @@
// Prescaler, timer, duty compare and dead-band state, updated once per accepted item.
`default_nettype none
module tpwm_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tpwm_pkg::cfg_t       cfg,
  input  wire logic                 accept,
  input  wire tpwm_pkg::item_t      item,
  output tpwm_pkg::result_t         result
);

  localparam int NC = tpwm_pkg::NUM_CHANNELS;

  logic [3:0]                        prescale_count, prescale_count_next;
  logic [1:0]                        phase_count, phase_count_next;
  logic [tpwm_pkg::TIMER_BITS-1:0]   timer_count, timer_count_next;
  logic [tpwm_pkg::DUTY_BITS-1:0]    duty_buffered [NC];
  logic [tpwm_pkg::DUTY_BITS-1:0]    duty_buffered_next [NC];
  logic [tpwm_pkg::DUTY_BITS-1:0]    duty_latched [NC];
  logic [tpwm_pkg::DUTY_BITS-1:0]    duty_latched_next [NC];
  logic [NC-1:0]                     raw_levels, raw_levels_next;
  logic [tpwm_pkg::DEADC_BITS-1:0]   dead_count, dead_count_next;
  logic [1:0]                        bridge_levels, bridge_levels_next;

  logic [3:0]                        limit;
  logic                              match;
  logic [tpwm_pkg::DUTY_BITS-1:0]    count;
  logic [1:0]                        want;

  always_comb begin
    case (cfg.prescale_select)
      tpwm_pkg::PRESCALE_DIV1: limit = tpwm_pkg::PRESCALE_LIMIT_1;
      tpwm_pkg::PRESCALE_DIV4: limit = tpwm_pkg::PRESCALE_LIMIT_4;
      default:                 limit = tpwm_pkg::PRESCALE_LIMIT_16;
    endcase
  end

  always_comb begin
    prescale_count_next = prescale_count;
    phase_count_next    = phase_count;
    timer_count_next    = timer_count;
    duty_buffered_next  = duty_buffered;
    duty_latched_next   = duty_latched;
    raw_levels_next     = raw_levels;
    dead_count_next     = dead_count;
    bridge_levels_next  = bridge_levels;
    match               = 1'b0;
    count               = '0;
    want                = 2'b01;

    if (item.kind == tpwm_pkg::KIND_DUTY_WRITE) begin
      for (int c = 0; c < NC; c++) begin
        if (item.channel == tpwm_pkg::CH_BITS'(c)) begin
          duty_buffered_next[c] = item.duty_value;
        end
      end
    end else if (!cfg.timer_on) begin
      raw_levels_next    = '0;
      bridge_levels_next = 2'b00;
      dead_count_next    = '0;
    end else begin
      if (prescale_count >= limit) begin
        prescale_count_next = '0;
        if (phase_count == 2'd3) begin
          phase_count_next = '0;
          if (timer_count == cfg.period) begin
            timer_count_next = '0;
            match            = 1'b1;
            for (int c = 0; c < NC; c++) begin
              duty_latched_next[c] = duty_buffered[c];
              raw_levels_next[c]   = (duty_buffered[c] != '0);
            end
          end else begin
            timer_count_next = timer_count + 1'b1;
          end
        end else begin
          phase_count_next = phase_count + 1'b1;
        end
      end else begin
        prescale_count_next = prescale_count + 1'b1;
      end

      count = {timer_count_next, phase_count_next};
      for (int c = 0; c < NC; c++) begin
        if (count == duty_latched_next[c]) begin
          raw_levels_next[c] = 1'b0;
        end
      end

      want = raw_levels_next[0] ? 2'b10 : 2'b01;
      if (!cfg.output_mode) begin
        bridge_levels_next = want;
        dead_count_next    = '0;
      end else if (raw_levels_next[0] != raw_levels[0]) begin
        dead_count_next    = {cfg.dead_band, 2'b00};
        bridge_levels_next = (cfg.dead_band == '0) ? want : 2'b00;
      end else if (dead_count != '0) begin
        dead_count_next = dead_count - 1'b1;
        if (dead_count_next == '0) begin
          bridge_levels_next = want;
        end
      end
    end
  end

  always_comb begin
    result.period_match = match;
    result.timer_value  = timer_count_next;
    result.out_second   = (NC > 1) ? raw_levels_next[NC-1] : 1'b0;
    if (cfg.output_mode) begin
      result.out_a = bridge_levels_next[1] ^ cfg.polarity[1];
      result.out_b = bridge_levels_next[0] ^ cfg.polarity[0];
    end else begin
      result.out_a = raw_levels_next[0] ^ cfg.polarity[1];
      result.out_b = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      phase_count    <= '0;
      timer_count    <= '0;
      raw_levels     <= '0;
      dead_count     <= '0;
      bridge_levels  <= 2'b00;
      for (int c = 0; c < NC; c++) begin
        duty_buffered[c] <= '0;
        duty_latched[c]  <= '0;
      end
    end else if (accept) begin
      prescale_count <= prescale_count_next;
      phase_count    <= phase_count_next;
      timer_count    <= timer_count_next;
      raw_levels     <= raw_levels_next;
      dead_count     <= dead_count_next;
      bridge_levels  <= bridge_levels_next;
      duty_buffered  <= duty_buffered_next;
      duty_latched   <= duty_latched_next;
    end
  end

endmodule
`default_nettype wire

@@ design/tpwm_skid.sv @@
// Result register with a skid stage, so that a stalled receiver does not stop intake.
`default_nettype none
module tpwm_skid (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tpwm_pkg::result_t push_data,
  output logic               push_ready,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output tpwm_pkg::result_t  pop_data
);

  logic              main_valid;
  tpwm_pkg::result_t main_data;
  logic              skid_valid;
  tpwm_pkg::result_t skid_data;

  assign push_ready = !skid_valid;
  assign pop_valid  = main_valid;
  assign pop_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
        main_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ design/timer_pwm_generator_with_deadband.sv @@
// Top level of the two-channel PWM generator with prescaler and half-bridge dead band.
// The cmd channel carries one item per transfer: either one oscillator tick or a write
// of a channel's buffered duty. Every accepted item yields exactly one result transfer
// on the res channel, giving the pin levels, the period match flag and the timer value
// after that item. Configuration is written through cfg_wr_en, cfg_index and cfg_data,
// one register per clock; the user must write it only while no item is in flight, as
// the block does not enforce this. An item is worked out in the cycle it is accepted
// and its result is registered; one item can be accepted on every clock while the skid
// stage is not full. The single state update per accepted item (prescaler, timer and
// dead-band counter) sets this rate. When the receiver stalls, the result register
// holds, a skid stage takes one more result, and cmd.ready falls only once it is full.
// A synchronous reset restores the register defaults (period 255, timer off, single
// output mode), clears the counters and duties, and empties the result stages.
`default_nettype none
module timer_pwm_generator_with_deadband (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tpwm_pkg::IDX_BITS-1:0] cfg_index,
  input  wire logic [tpwm_pkg::CFG_BITS-1:0] cfg_data,
  tpwm_cmd_if.sink                           cmd,
  tpwm_res_if.source                         res
);

  tpwm_pkg::cfg_t    cfg;
  tpwm_pkg::item_t   item;
  tpwm_pkg::result_t result;
  tpwm_pkg::result_t res_data;
  logic              accept;
  logic              push_ready;

  assign item.kind       = cmd.kind;
  assign item.channel    = cmd.channel;
  assign item.duty_value = cmd.duty_value;
  assign cmd.ready       = push_ready;
  assign accept          = cmd.valid && push_ready;

  tpwm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpwm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (item),
    .result (result)
  );

  tpwm_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .push_ready (push_ready),
    .pop_valid  (res.valid),
    .pop_ready  (res.ready),
    .pop_data   (res_data)
  );

  assign res.out_a        = res_data.out_a;
  assign res.out_b        = res_data.out_b;
  assign res.out_second   = res_data.out_second;
  assign res.period_match = res_data.period_match;
  assign res.timer_value  = res_data.timer_value;

endmodule
`default_nettype wire

@@ verif/timer_pwm_generator_with_deadband_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the two-channel PWM generator with prescaler and dead band.
module timer_pwm_generator_with_deadband_tb;

  localparam int TOTAL_ITEMS = 1050;
  localparam int QUIET_ITEMS = 150;
  localparam int STALL_LIMIT = 1000;
  localparam int DIR_ROWS    = 36;

  localparam logic [1:0]                     PRESCALE_RESERVED = 2'd3;
  localparam logic [1:0]                     POL_A_LOW         = 2'b10;
  localparam logic [1:0]                     POL_BOTH_LOW      = 2'b11;
  localparam logic [tpwm_pkg::DEAD_BITS-1:0] DEAD_MAX          = '1;
  localparam logic [tpwm_pkg::DUTY_BITS-1:0] DUTY_MAX          = '1;

  localparam tpwm_pkg::result_t ALL_LOW = '0;
  localparam tpwm_pkg::result_t A_HIGH  = '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0};
  localparam tpwm_pkg::result_t AB_HIGH = '{1'b1, 1'b1, 1'b0, 1'b0, 8'd0};

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_DUTY,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                      what;
    logic [2:0]                     sel;
    logic [tpwm_pkg::DUTY_BITS-1:0] value;
    logic                           fixed;
    tpwm_pkg::result_t              want;
  } dir_row_t;

  // Fixed results are given only where the block is still off after reset.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b1, ALL_LOW},
    '{ROW_DUTY, 3'd1,                      DUTY_MAX,               1'b1, ALL_LOW},
    '{ROW_DUTY, 3'd0,                      10'd0,                  1'b1, ALL_LOW},
    '{ROW_REG,  tpwm_pkg::REG_POLARITY,    10'(POL_BOTH_LOW),      1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b1, A_HIGH},
    '{ROW_REG,  tpwm_pkg::REG_OUTPUT_MODE, 10'd1,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b1, AB_HIGH},
    '{ROW_REG,  tpwm_pkg::REG_OUTPUT_MODE, 10'd0,                  1'b0, ALL_LOW},
    '{ROW_REG,  tpwm_pkg::REG_POLARITY,    10'd0,                  1'b0, ALL_LOW},
    '{ROW_REG,  tpwm_pkg::REG_PERIOD,      10'd0,                  1'b0, ALL_LOW},
    '{ROW_REG,  tpwm_pkg::REG_TIMER_ON,    10'd1,                  1'b0, ALL_LOW},
    '{ROW_DUTY, 3'd0,                      10'd2,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_REG,  tpwm_pkg::REG_OUTPUT_MODE, 10'd1,                  1'b0, ALL_LOW},
    '{ROW_REG,  tpwm_pkg::REG_POLARITY,    10'(POL_A_LOW),         1'b0, ALL_LOW},
    '{ROW_REG,  tpwm_pkg::REG_DEAD_BAND,   10'd1,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_REG,  tpwm_pkg::REG_PRESCALE,    10'(PRESCALE_RESERVED), 1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_REG,  tpwm_pkg::REG_DEAD_BAND,   10'(DEAD_MAX),          1'b0, ALL_LOW},
    '{ROW_REG,  tpwm_pkg::REG_PERIOD,      10'd255,                1'b0, ALL_LOW},
    '{ROW_REG,  tpwm_pkg::REG_PRESCALE,    10'(tpwm_pkg::PRESCALE_DIV4), 1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW},
    '{ROW_TICK, 3'd0,                      10'd0,                  1'b0, ALL_LOW}
  };

  logic                          clk;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [tpwm_pkg::IDX_BITS-1:0] cfg_index;
  logic [tpwm_pkg::CFG_BITS-1:0] cfg_data;

  tpwm_cmd_if cmd ();
  tpwm_res_if res ();

  timer_pwm_generator_with_deadband u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .res       (res)
  );

  tpwm_pkg::cfg_t                    cfg;
  logic [3:0]                        psc_cnt;
  logic [1:0]                        phase;
  logic [tpwm_pkg::TIMER_BITS-1:0]   tmr;
  logic [tpwm_pkg::DUTY_BITS-1:0]    duty_buf [tpwm_pkg::NUM_CHANNELS];
  logic [tpwm_pkg::DUTY_BITS-1:0]    duty_act [tpwm_pkg::NUM_CHANNELS];
  logic [tpwm_pkg::NUM_CHANNELS-1:0] level;
  logic [tpwm_pkg::DEADC_BITS-1:0]   dead_cnt;
  logic [1:0]                        bridge;

  tpwm_pkg::result_t pending [$];
  int      mismatches  = 0;
  int      items_sent  = 0;
  int      idle_cycles = 0;
  bit      gaps_on     = 1'b1;
  bit      rx_stalls   = 1'b1;
  bit      quiet       = 1'b0;

  always #5 clk = ~clk;

  function automatic tpwm_pkg::result_t pwm_step(input tpwm_pkg::item_t it);
    tpwm_pkg::result_t              r;
    logic [3:0]                     limit;
    logic                           old0;
    logic [1:0]                     want;
    logic [tpwm_pkg::DUTY_BITS-1:0] count;
    r = '0;
    if (it.kind == tpwm_pkg::KIND_DUTY_WRITE) begin
      if (int'(it.channel) < tpwm_pkg::NUM_CHANNELS) duty_buf[it.channel] = it.duty_value;
    end else if (!cfg.timer_on) begin
      level    = '0;
      bridge   = 2'b00;
      dead_cnt = '0;
    end else begin
      old0 = level[0];
      case (cfg.prescale_select)
        tpwm_pkg::PRESCALE_DIV1: limit = tpwm_pkg::PRESCALE_LIMIT_1;
        tpwm_pkg::PRESCALE_DIV4: limit = tpwm_pkg::PRESCALE_LIMIT_4;
        default: limit = tpwm_pkg::PRESCALE_LIMIT_16;
      endcase
      if (psc_cnt >= limit) begin
        psc_cnt = '0;
        if (phase == 2'd3) begin
          phase = 2'd0;
          if (tmr == cfg.period) begin
            tmr = '0;
            r.period_match = 1'b1;
            for (int c = 0; c < tpwm_pkg::NUM_CHANNELS; c++) begin
              duty_act[c] = duty_buf[c];
              level[c]    = (duty_act[c] != '0);
            end
          end else begin
            tmr = tmr + 1'b1;
          end
        end else begin
          phase = phase + 1'b1;
        end
      end else begin
        psc_cnt = psc_cnt + 1'b1;
      end
      count = {tmr, phase};
      for (int c = 0; c < tpwm_pkg::NUM_CHANNELS; c++)
        if (count == duty_act[c]) level[c] = 1'b0;
      want = level[0] ? 2'b10 : 2'b01;
      if (!cfg.output_mode) begin
        bridge   = want;
        dead_cnt = '0;
      end else if (level[0] != old0) begin
        dead_cnt = {cfg.dead_band, 2'b00};
        bridge   = (dead_cnt == '0) ? want : 2'b00;
      end else if (dead_cnt != '0) begin
        dead_cnt = dead_cnt - 1'b1;
        if (dead_cnt == '0) bridge = want;
      end
    end
    if (cfg.output_mode) begin
      r.out_a = bridge[1] ^ cfg.polarity[1];
      r.out_b = bridge[0] ^ cfg.polarity[0];
    end else begin
      r.out_a = level[0] ^ cfg.polarity[1];
      r.out_b = 1'b0;
    end
    r.out_second  = (tpwm_pkg::NUM_CHANNELS > 1) ? level[tpwm_pkg::NUM_CHANNELS-1] : 1'b0;
    r.timer_value = tmr;
    return r;
  endfunction

  task automatic write_reg(input tpwm_pkg::reg_index_t idx,
                           input logic [tpwm_pkg::CFG_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      tpwm_pkg::REG_PERIOD:      cfg.period          = v;
      tpwm_pkg::REG_PRESCALE:    cfg.prescale_select = v[1:0];
      tpwm_pkg::REG_TIMER_ON:    cfg.timer_on        = v[0];
      tpwm_pkg::REG_OUTPUT_MODE: cfg.output_mode     = v[0];
      tpwm_pkg::REG_POLARITY:    cfg.polarity        = v[1:0];
      tpwm_pkg::REG_DEAD_BAND:   cfg.dead_band       = v[tpwm_pkg::DEAD_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_item(input tpwm_pkg::item_t it, input bit use_fixed,
                           input tpwm_pkg::result_t fixed);
    tpwm_pkg::result_t predicted;
    cfg_wr_en      <= 1'b0;
    cmd.valid      <= 1'b1;
    cmd.kind       <= it.kind;
    cmd.channel    <= it.channel;
    cmd.duty_value <= it.duty_value;
    do @(posedge clk); while (!cmd.ready);
    @(negedge clk);
    predicted = pwm_step(it);
    pending.push_back(use_fixed ? fixed : predicted);
    items_sent++;
  endtask

  task automatic pause();
    if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    tpwm_pkg::item_t                it;
    dir_row_t                       row;
    logic [7:0]                     per;
    logic [1:0]                     psc;
    logic [tpwm_pkg::DEAD_BITS-1:0] dead;
    int                             sel;
    int                             phase_len;
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = tpwm_pkg::REG_PERIOD;
    cfg_data       = '0;
    cmd.valid      = 1'b0;
    cmd.kind       = tpwm_pkg::KIND_TICK;
    cmd.channel    = '0;
    cmd.duty_value = '0;
    cfg            = '0;
    cfg.period     = '1;
    psc_cnt        = '0;
    phase          = '0;
    tmr            = '0;
    level          = '0;
    dead_cnt       = '0;
    bridge         = 2'b00;
    for (int c = 0; c < tpwm_pkg::NUM_CHANNELS; c++) begin
      duty_buf[c] = '0;
      duty_act[c] = '0;
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[n]) begin
      row = DIRECTED[n];
      if (row.what == ROW_REG) begin
        drain();
        write_reg(tpwm_pkg::reg_index_t'(row.sel), row.value[tpwm_pkg::CFG_BITS-1:0]);
      end else begin
        it.kind       = (row.what == ROW_DUTY) ? tpwm_pkg::KIND_DUTY_WRITE :
                        tpwm_pkg::KIND_TICK;
        it.channel    = row.sel[tpwm_pkg::CH_BITS-1:0];
        it.duty_value = row.value;
        send_item(it, row.fixed, row.want);
        pause();
      end
    end

    while (items_sent < TOTAL_ITEMS) begin
      drain();
      sel = $urandom_range(0, 9);
      psc = (sel < 5) ? tpwm_pkg::PRESCALE_DIV1 : (sel < 8) ? tpwm_pkg::PRESCALE_DIV4 :
            (sel == 8) ? tpwm_pkg::PRESCALE_DIV16 : PRESCALE_RESERVED;
      if (tmr > 8'd1 && psc != tpwm_pkg::PRESCALE_DIV1) psc = tpwm_pkg::PRESCALE_DIV4;
      if (tmr > 8'd5) psc = tpwm_pkg::PRESCALE_DIV1;
      case ($urandom_range(0, 9))
        0: per = 8'd0;
        1: per = 8'd255;
        default: per = (psc == tpwm_pkg::PRESCALE_DIV1) ? 8'($urandom_range(1, 24)) :
                       (psc == tpwm_pkg::PRESCALE_DIV4) ? 8'($urandom_range(1, 5)) :
                       8'($urandom_range(0, 1));
      endcase
      if (per < tmr) per = tmr;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: dead = '0;
        4, 5, 6, 7: dead = tpwm_pkg::DEAD_BITS'($urandom_range(1, 3));
        8: dead = DEAD_MAX;
        default: dead = tpwm_pkg::DEAD_BITS'($urandom_range(0, 127));
      endcase
      write_reg(tpwm_pkg::REG_PERIOD, per);
      write_reg(tpwm_pkg::REG_PRESCALE, 8'(psc));
      write_reg(tpwm_pkg::REG_TIMER_ON, 8'($urandom_range(0, 9) != 0));
      write_reg(tpwm_pkg::REG_OUTPUT_MODE, 8'($urandom_range(0, 4) < 3));
      write_reg(tpwm_pkg::REG_POLARITY, 8'($urandom_range(0, 3)));
      write_reg(tpwm_pkg::REG_DEAD_BAND, 8'(dead));
      gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls = !quiet && ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(15, 70);
      for (int k = 0; k < phase_len && items_sent < TOTAL_ITEMS; k++) begin
        if (!quiet && items_sent >= TOTAL_ITEMS - QUIET_ITEMS) begin
          quiet     = 1'b1;
          rx_stalls = 1'b0;
        end
        it.channel    = tpwm_pkg::CH_BITS'($urandom_range(0, 1));
        it.duty_value = tpwm_pkg::DUTY_BITS'($urandom_range(0, 1023));
        if ($urandom_range(0, 4) == 0) begin
          it.kind = tpwm_pkg::KIND_DUTY_WRITE;
          case ($urandom_range(0, 7))
            0: it.duty_value = '0;
            1: it.duty_value = DUTY_MAX;
            2, 3: ;
            default: it.duty_value =
              tpwm_pkg::DUTY_BITS'($urandom_range(0, int'({cfg.period, 2'b11})));
          endcase
        end else begin
          it.kind = tpwm_pkg::KIND_TICK;
        end
        send_item(it, 1'b0, ALL_LOW);
        pause();
      end
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : result_sink
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stalls && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    tpwm_pkg::result_t got;
    tpwm_pkg::result_t want;
    if (!rst && res.valid && res.ready) begin
      got = {res.out_a, res.out_b, res.out_second, res.period_match, res.timer_value};
      if (pending.size() == 0) begin
        if (mismatches < 10) $display("unexpected result transfer at %0t", $time);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("result mismatch at %0t: expected a=%0b b=%0b second=%0b match=%0b ",
                     $time, want.out_a, want.out_b, want.out_second, want.period_match,
                     "timer=%0d, got a=%0b b=%0b second=%0b match=%0b timer=%0d",
                     want.timer_value, got.out_a, got.out_b, got.out_second,
                     got.period_match, got.timer_value);
          mismatches++;
        end
      end
    end
  end

  // The run is abandoned once no transfer has happened for too long.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
design/tpwm_pkg.sv
design/tpwm_if.sv
design/tpwm_regs.sv
design/tpwm_core.sv
design/tpwm_skid.sv
design/timer_pwm_generator_with_deadband.sv
verif/timer_pwm_generator_with_deadband_tb.sv
